FILE: src/knxb_pkg.sv
package knxb_pkg;

  // frame kinds as carried on the request tuser
  typedef enum logic [1:0] {
    KIND_ROUTING    = 2'd0,
    KIND_TUNNEL     = 2'd1,
    KIND_CONNECT    = 2'd2,
    KIND_DISCONNECT = 2'd3
  } kind_e;

  // register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_SRC_ADDR  = 3'd0,
    REG_GROUP_TGT = 3'd1,
    REG_LOCAL_IP  = 3'd2,
    REG_UDP_PORT  = 3'd3,
    REG_NAT_MODE  = 3'd4
  } reg_idx_e;

  localparam int unsigned IdxW = 5;

  // frame lengths in bytes
  localparam logic [IdxW-1:0] LenRouting    = 5'd19;
  localparam logic [IdxW-1:0] LenTunnel     = 5'd23;
  localparam logic [IdxW-1:0] LenConnect    = 5'd26;
  localparam logic [IdxW-1:0] LenDisconnect = 5'd16;

  // KNXnet/IP header
  localparam logic [7:0]  HdrSize        = 8'h06;
  localparam logic [7:0]  ProtoVer       = 8'h10;
  localparam logic [15:0] SvcRoutingInd  = 16'h0530;
  localparam logic [15:0] SvcTunnelReq   = 16'h0420;
  localparam logic [15:0] SvcConnectReq  = 16'h0205;
  localparam logic [15:0] SvcDisconnReq  = 16'h0209;

  // cEMI / connection header / CRI
  localparam logic [7:0] CemiLDataInd    = 8'h29;
  localparam logic [7:0] CemiLDataReq    = 8'h11;
  localparam logic [7:0] ConnHdrLen      = 8'h04;
  localparam logic [7:0] CriLen          = 8'h04;
  localparam logic [7:0] CriTunnelConn   = 8'h04;
  localparam logic [7:0] CriLinkLayer    = 8'h02;

  // telegram
  localparam logic [7:0] Ctrl1           = 8'hBC;
  localparam logic [7:0] Ctrl2           = 8'hE0;
  localparam logic [7:0] NpduLen         = 8'h03;
  localparam logic [7:0] ApciGrpWrite    = 8'h80;

  // HPAI
  localparam logic [7:0] HpaiLen         = 8'h08;
  localparam logic [7:0] HpaiUdp         = 8'h01;

  typedef struct packed {
    logic [15:0] source_address;
    logic [15:0] group_target;
    logic [31:0] local_ip;
    logic [15:0] server_udp_port;
    logic        nat_mode;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  channel_id;
    logic [7:0]  sequence_number;
    logic [15:0] dpt9;
  } frame_t;

  function automatic logic [IdxW-1:0] last_idx(kind_e k);
    logic [IdxW-1:0] r;
    case (k)
      KIND_ROUTING:    r = LenRouting - 5'd1;
      KIND_TUNNEL:     r = LenTunnel - 5'd1;
      KIND_CONNECT:    r = LenConnect - 5'd1;
      KIND_DISCONNECT: r = LenDisconnect - 5'd1;
      default:         r = LenConnect - 5'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: src/knxb_dpt9_enc.sv
// tenths of a degree -> value*10 -> DPT 9 half float (4-bit exp, 12-bit mantissa)
module knxb_dpt9_enc
  import knxb_pkg::*;
(
  input  logic signed [15:0] temperature_i,
  output logic [15:0]        dpt9_o
);

  logic        neg;
  logic [15:0] mag;
  logic [18:0] mag10;
  logic [3:0]  expo;
  logic [18:0] shifted;
  logic [11:0] mant;

  assign neg   = temperature_i[15];
  assign mag   = neg ? 16'(~temperature_i + 16'sd1) : temperature_i;
  assign mag10 = (19'(mag) << 3) + (19'(mag) << 1);

  // exponent is one past the top set bit above bit 10
  always_comb begin
    expo = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (mag10[11+k]) expo = 4'(k + 1);
    end
  end

  assign shifted = mag10 >> expo;
  assign mant    = neg ? 12'(~{1'b0, shifted[10:0]} + 12'd1) : {1'b0, shifted[10:0]};
  assign dpt9_o  = {mant[11], expo, mant[10:0]};

endmodule

FILE: src/knxb_byte_mux.sv
// picks frame byte idx_i for the held request
module knxb_byte_mux
  import knxb_pkg::*;
(
  input  frame_t          frm_i,
  input  cfg_t            cfg_i,
  input  logic [IdxW-1:0] idx_i,
  output logic [7:0]      byte_o
);

  logic [IdxW-1:0] rt_tel;
  logic [IdxW-1:0] tn_tel;
  logic [IdxW-1:0] cn_ep0;
  logic [IdxW-1:0] cn_ep1;
  logic [IdxW-1:0] dc_ep;

  assign rt_tel = idx_i - 5'd8;
  assign tn_tel = idx_i - 5'd12;
  assign cn_ep0 = idx_i - 5'd6;
  assign cn_ep1 = idx_i - 5'd14;
  assign dc_ep  = idx_i - 5'd8;

  function automatic logic [7:0] hdr_byte(logic [2:0] i, logic [15:0] svc,
                                          logic [IdxW-1:0] len);
    logic [7:0] b;
    case (i)
      3'd0:    b = HdrSize;
      3'd1:    b = ProtoVer;
      3'd2:    b = svc[15:8];
      3'd3:    b = svc[7:0];
      3'd4:    b = 8'h00;
      3'd5:    b = 8'(len);
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tel_byte(logic [3:0] i, cfg_t c, logic [15:0] f);
    logic [7:0] b;
    case (i)
      4'd0:    b = Ctrl1;
      4'd1:    b = Ctrl2;
      4'd2:    b = c.source_address[15:8];
      4'd3:    b = c.source_address[7:0];
      4'd4:    b = c.group_target[15:8];
      4'd5:    b = c.group_target[7:0];
      4'd6:    b = NpduLen;
      4'd7:    b = 8'h00;
      4'd8:    b = ApciGrpWrite;
      4'd9:    b = f[15:8];
      4'd10:   b = f[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ep_byte(logic [2:0] i, cfg_t c, logic zero);
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  b;
    ip   = zero ? 32'd0 : c.local_ip;
    port = zero ? 16'd0 : c.server_udp_port;
    case (i)
      3'd0:    b = HpaiLen;
      3'd1:    b = HpaiUdp;
      3'd2:    b = ip[7:0];
      3'd3:    b = ip[15:8];
      3'd4:    b = ip[23:16];
      3'd5:    b = ip[31:24];
      3'd6:    b = port[15:8];
      3'd7:    b = port[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  always_comb begin
    byte_o = 8'h00;
    case (frm_i.kind)
      KIND_ROUTING: begin
        if (idx_i < 5'd6)       byte_o = hdr_byte(idx_i[2:0], SvcRoutingInd, LenRouting);
        else if (idx_i == 5'd6) byte_o = CemiLDataInd;
        else if (idx_i == 5'd7) byte_o = 8'h00;
        else                    byte_o = tel_byte(rt_tel[3:0], cfg_i, frm_i.dpt9);
      end
      KIND_TUNNEL: begin
        if (idx_i < 5'd6)        byte_o = hdr_byte(idx_i[2:0], SvcTunnelReq, LenTunnel);
        else if (idx_i == 5'd6)  byte_o = ConnHdrLen;
        else if (idx_i == 5'd7)  byte_o = frm_i.channel_id;
        else if (idx_i == 5'd8)  byte_o = frm_i.sequence_number;
        else if (idx_i == 5'd9)  byte_o = 8'h00;
        else if (idx_i == 5'd10) byte_o = CemiLDataReq;
        else if (idx_i == 5'd11) byte_o = 8'h00;
        else                     byte_o = tel_byte(tn_tel[3:0], cfg_i, frm_i.dpt9);
      end
      KIND_CONNECT: begin
        if (idx_i < 5'd6)        byte_o = hdr_byte(idx_i[2:0], SvcConnectReq, LenConnect);
        else if (idx_i < 5'd14)  byte_o = ep_byte(cn_ep0[2:0], cfg_i, cfg_i.nat_mode);
        else if (idx_i < 5'd22)  byte_o = ep_byte(cn_ep1[2:0], cfg_i, cfg_i.nat_mode);
        else if (idx_i == 5'd22) byte_o = CriLen;
        else if (idx_i == 5'd23) byte_o = CriTunnelConn;
        else if (idx_i == 5'd24) byte_o = CriLinkLayer;
        else                     byte_o = 8'h00;
      end
      KIND_DISCONNECT: begin
        if (idx_i < 5'd6)       byte_o = hdr_byte(idx_i[2:0], SvcDisconnReq, LenDisconnect);
        else if (idx_i == 5'd6) byte_o = frm_i.channel_id;
        else if (idx_i == 5'd7) byte_o = 8'h00;
        else                    byte_o = ep_byte(dc_ep[2:0], cfg_i, 1'b0);
      end
      default: byte_o = 8'h00;
    endcase
  end

endmodule

FILE: src/knxnet_ip_frame_builder_unit.sv
// Channel   | Dir | Group          | Content
// request   | in  | s_axis_*       | tuser: kind; tdata: temperature, channel, sequence
// frame     | out | m_axis_*       | tdata: frame byte; tlast: final byte of the frame
// config    | in  | APB (psel ...) | five registers at byte address 4*index
//
// One frame byte leaves per cycle unless m_axis_tready stalls: a frame has 16, 19, 23 or 26 bytes
// (disconnect, routing, tunneling, connect), set by the byte counter over the request register.
// The next request is taken in the cycle the last byte moves to the output register, so frames
// stream without gaps. The first byte passes the request register, then the output register.
// Reset clears both valid flags, the counter and the configuration registers; data regs are not.
// A stall on m_axis_tready holds both registers; s_axis_tready stays low until the last byte goes.
module knxnet_ip_frame_builder_unit
  import knxb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] temperature, [23:16] channel_id,
                                     // [31:24] sequence_number
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  // frame byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] frame_byte
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --- configuration registers ---
  cfg_t     cfg_q;
  reg_idx_e reg_sel;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SRC_ADDR:  cfg_q.source_address  <= pwdata[15:0];
        REG_GROUP_TGT: cfg_q.group_target    <= pwdata[15:0];
        REG_LOCAL_IP:  cfg_q.local_ip        <= pwdata;
        REG_UDP_PORT:  cfg_q.server_udp_port <= pwdata[15:0];
        REG_NAT_MODE:  cfg_q.nat_mode        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SRC_ADDR:  prdata = {16'd0, cfg_q.source_address};
      REG_GROUP_TGT: prdata = {16'd0, cfg_q.group_target};
      REG_LOCAL_IP:  prdata = cfg_q.local_ip;
      REG_UDP_PORT:  prdata = {16'd0, cfg_q.server_udp_port};
      REG_NAT_MODE:  prdata = {31'd0, cfg_q.nat_mode};
      default:       prdata = 32'd0;
    endcase
  end

  // --- request register: float is encoded on the way in ---
  frame_t          frm_q, frm_d;
  logic            frm_vld_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0]     dpt9;
  logic            in_req;
  logic            advance;
  logic            is_last;
  logic [7:0]      cur_byte;

  knxb_dpt9_enc u_enc (
    .temperature_i (s_axis_tdata[15:0]),
    .dpt9_o        (dpt9)
  );

  assign frm_d.kind            = kind_e'(s_axis_tuser);
  assign frm_d.channel_id      = s_axis_tdata[23:16];
  assign frm_d.sequence_number = s_axis_tdata[31:24];
  assign frm_d.dpt9            = dpt9;

  // output register free or draining this cycle
  assign advance       = frm_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign is_last       = (idx_q == last_idx(frm_q.kind));
  assign s_axis_tready = !frm_vld_q || (advance && is_last);
  assign in_req        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (in_req) begin
      frm_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (advance && is_last) begin
      frm_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (advance) begin
      idx_q     <= idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) frm_q <= frm_d;
  end

  knxb_byte_mux u_mux (
    .frm_i  (frm_q),
    .cfg_i  (cfg_q),
    .idx_i  (idx_q),
    .byte_o (cur_byte)
  );

  // --- output register ---
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= cur_byte;
      out_last_q <= is_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: src/knxb_checker.sv
module knxb_checker
  import knxb_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  logic            out_req;
  logic [IdxW-1:0] cnt_q;

  assign out_req = m_axis_tvalid && m_axis_tready;

  // bytes delivered since the last frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (out_req && m_axis_tlast) begin
      cnt_q <= '0;
    end else if (out_req) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req && cnt_q == 5'd0 |-> m_axis_tdata == HdrSize)
    else $error("frame does not open with header size");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req && m_axis_tlast |->
      (cnt_q == LenRouting - 5'd1) || (cnt_q == LenTunnel - 5'd1) ||
      (cnt_q == LenConnect - 5'd1) || (cnt_q == LenDisconnect - 5'd1))
    else $error("tlast at a length no frame has");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req && cnt_q == LenConnect - 5'd1 |-> m_axis_tlast)
    else $error("frame longer than the longest kind");

endmodule

bind knxnet_ip_frame_builder_unit knxb_checker u_knxb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
